>>> src/pqbp_pkg.sv
// Shared types, constants and the per-pixel packing function of the bit packer.
package pqbp_pkg;

   // Stream and queue geometry.
   localparam int unsigned ByteBits   = 8;
   localparam int unsigned QueueDepth = 3;
   localparam logic [2:0]  WidthReset = 3'd4;

   // One response entry as it travels through the output queue.
   typedef struct packed {
      logic [7:0] packed_byte;
      logic       last_byte;
   } rsp_entry_type;

   // Up to two responses written into the queue in one cycle.
   typedef struct packed {
      logic [1:0]    count;
      rsp_entry_type first;
      rsp_entry_type second;
   } push_type;

   // Everything one pixel produces: queue writes and the next packer state.
   typedef struct packed {
      push_type   push;
      logic [7:0] next_partial;
      logic [2:0] next_filled;
   } step_result_type;

   // Advance a queue pointer by one, wrapping at the queue depth.
   function automatic logic [1:0] ptr_inc(input logic [1:0] ptr);
      logic [1:0] nxt;
      if (ptr == 2'(QueueDepth - 1)) begin
         nxt = 2'd0;
      end else begin
         nxt = ptr + 2'd1;
      end
      return nxt;
   endfunction

   // Reduce one pixel to its code, append it MSB-first to the pending bits and
   // emit a full byte and, at end of image, the left-aligned flush byte.
   function automatic step_result_type pack_step(
      input logic [7:0] partial,
      input logic [2:0] filled,
      input logic [2:0] width,
      input logic [7:0] pixel,
      input logic       eoi
   );
      logic [7:0]      code;
      logic [14:0]     acc;
      logic [3:0]      total;
      logic [3:0]      rem;
      logic [7:0]      flush;
      step_result_type r;

      r     = '0;
      rem   = '0;
      // Keep the top bits of the pixel; a width of zero shifts everything out.
      code  = pixel >> (4'd8 - {1'b0, width});
      acc   = ({7'd0, partial} << width) | {7'd0, code};
      total = {1'b0, filled} + {1'b0, width};

      // A full byte leaves the accumulator as soon as it fills.
      if (total >= 4'(ByteBits)) begin
         rem                         = total - 4'(ByteBits);
         r.push.first.packed_byte    = 8'(acc >> rem);
         r.push.first.last_byte      = 1'b0;
         r.push.count                = 2'd1;
         total                       = rem;
         acc                         = acc & ((15'd1 << rem) - 15'd1);
      end

      // At end of image, flush any pending bits and start a fresh stream.
      if (eoi) begin
         if (total != 4'd0) begin
            flush = 8'(acc << (4'd8 - total));
            if (r.push.count == 2'd0) begin
               r.push.first.packed_byte = flush;
               r.push.first.last_byte   = 1'b1;
            end else begin
               r.push.second.packed_byte = flush;
               r.push.second.last_byte   = 1'b1;
            end
            r.push.count = r.push.count + 2'd1;
         end else if (r.push.count != 2'd0) begin
            r.push.first.last_byte = 1'b1;
         end
         r.next_partial = 8'd0;
         r.next_filled  = 3'd0;
      end else begin
         r.next_partial = acc[7:0];
         r.next_filled  = total[2:0];
      end
      return r;
   endfunction

endpackage

>>> src/pqbp_rsp_queue.sv
// Three-entry response queue that takes up to two bytes per cycle and gives one.
module pqbp_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  pqbp_pkg::push_type      push,
   output logic                    push_ready,
   input  logic                    pop,
   output logic                    head_valid,
   output pqbp_pkg::rsp_entry_type head
);

   pqbp_pkg::rsp_entry_type entry_ff [pqbp_pkg::QueueDepth];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic [1:0] wr_ptr_next;

   // Room for the worst case of two bytes from the next request.
   assign push_ready  = (count_ff <= 2'd1);
   assign head_valid  = (count_ff != 2'd0);
   assign head        = entry_ff[rd_ptr_ff];
   assign wr_ptr_next = pqbp_pkg::ptr_inc(wr_ptr_ff);

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.count == 2'd1) begin
         wr_ptr_in = wr_ptr_next;
      end else if (push.count == 2'd2) begin
         wr_ptr_in = pqbp_pkg::ptr_inc(wr_ptr_next);
      end
      rd_ptr_in = pop ? pqbp_pkg::ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + push.count - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; the first byte goes to the write pointer, the second after it.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

>>> src/pixel_quantize_bit_packer_core.sv
// Top level: quantizes gray pixels and packs the codes MSB-first into bytes.
// A byte completed by a request is written into the response queue at acceptance.
// Throughput: one pixel per cycle while each pixel yields at most one byte and rsp_ready
// holds; the single response port sets the limit and sends two bytes one by one.
// A three-entry response queue lets requests proceed while responses are stalled.
// Reset (synchronous): empties the queue, clears pending bits and sets the width to 4.
module pixel_quantize_bit_packer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_pixel,
   input  logic       req_end_of_image,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_packed_byte,
   output logic       rsp_last_byte,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_write_data
);

   logic [2:0] width_ff,   width_in;
   logic [7:0] partial_ff, partial_in;
   logic [2:0] filled_ff,  filled_in;
   logic       req_accept;
   logic       queue_ready;
   pqbp_pkg::step_result_type step;
   pqbp_pkg::push_type        push;
   pqbp_pkg::rsp_entry_type   head;

   assign req_ready  = queue_ready;
   assign req_accept = req_valid & queue_ready;

   // Packing logic for the current request.
   always_comb begin
      step = pqbp_pkg::pack_step(partial_ff, filled_ff, width_ff, req_pixel, req_end_of_image);
      push = req_accept ? step.push : '0;
   end

   // Next values of the configuration and the pending-bit state.
   always_comb begin
      width_in   = csr_write_enable ? csr_write_data : width_ff;
      partial_in = req_accept ? step.next_partial : partial_ff;
      filled_in  = req_accept ? step.next_filled  : filled_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= pqbp_pkg::WidthReset;
         partial_ff <= 8'd0;
         filled_ff  <= 3'd0;
      end else begin
         width_ff   <= width_in;
         partial_ff <= partial_in;
         filled_ff  <= filled_in;
      end
   end

   // Output queue decouples the byte stream from the response handshake.
   pqbp_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (queue_ready),
      .pop        (rsp_valid & rsp_ready),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_packed_byte = head.packed_byte;
   assign rsp_last_byte   = head.last_byte;

endmodule

>>> src/pqbp_checker.sv
// Port-level checker for the bit packer, bound to the top level.
module pqbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_packed_byte,
   input logic       rsp_last_byte
);

   // The queue is empty right after reset, so requests are taken at once.
   a_ready_after_reset: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request channel not ready after reset");

   // Back-pressure on requests only comes from bytes waiting in the queue.
   a_stall_needs_pending: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

   // A stalled response stays offered with the same byte.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packed_byte)
                                  && $stable(rsp_last_byte))
      else $error("stalled response changed");

   // An idle empty block with no request keeps the response side quiet.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !req_valid |=> !rsp_valid)
      else $error("response appeared without a request");

endmodule

bind pixel_quantize_bit_packer_core pqbp_checker u_pqbp_checker (.*);

>>> bench/pixel_quantize_bit_packer_core_test.sv
// Self-checking bench for the pixel quantizer and MSB-first bit packer core.
module pixel_quantize_bit_packer_core_test;

   localparam int unsigned HalfPeriod    = 10;
   localparam int unsigned ResetCycles   = 6;
   localparam int unsigned SettleCycles  = 4;
   localparam int unsigned DrainCycles   = 12;
   localparam int unsigned RandomPixels  = 1850;
   localparam int unsigned IdlePercent   = 24;
   localparam int unsigned HoldOffCycles = 120;
   localparam int unsigned TimeoutCycles = 400000;

   // Predicts the byte stream from accepted pixels and checks every byte that leaves.
   class packer_scoreboard;
      pqbp_pkg::rsp_entry_type expected_bytes[$];
      logic [7:0]    pending_bits;
      logic [2:0]    pending_count;
      logic [2:0]    code_width;
      int unsigned   mismatches;
      int unsigned   bytes_checked;
      int unsigned   pixels_noted;
      int unsigned   images_ended;

      function new();
         pending_bits  = 8'd0;
         pending_count = 3'd0;
         code_width    = pqbp_pkg::WidthReset;
         mismatches    = 0;
         bytes_checked = 0;
         pixels_noted  = 0;
         images_ended  = 0;
      endfunction

      function void set_width(input logic [2:0] width);
         code_width = width;
      endfunction

      function int unsigned outstanding();
         return expected_bytes.size();
      endfunction

      // Append one pixel's code to the pending bits and queue the bytes it completes.
      function void note_request(input logic [7:0] pixel, input logic end_of_image);
         logic [7:0]    code;
         logic [14:0]   window;
         int unsigned   bit_total;
         int unsigned   spare;
         bit            have_full;
         pqbp_pkg::rsp_entry_type full_byte;
         pqbp_pkg::rsp_entry_type flush_byte;

         have_full = 1'b0;
         full_byte = '0;
         flush_byte = '0;
         // The code keeps the top bits of the pixel; a zero width contributes nothing.
         code = (code_width == 3'd0) ? 8'd0 : 8'(pixel >> (8 - int'(code_width)));
         window = ({7'd0, pending_bits} << code_width) | {7'd0, code};
         bit_total = int'(pending_count) + int'(code_width);

         // A byte leaves as soon as eight bits are collected.
         if (bit_total >= 8) begin
            spare = bit_total - 8;
            full_byte.packed_byte = 8'(window >> spare);
            full_byte.last_byte = 1'b0;
            have_full = 1'b1;
            bit_total = spare;
            window = window & ((15'd1 << spare) - 15'd1);
         end

         // At the end of an image the leftover bits go out left-aligned.
         if (end_of_image) begin
            images_ended++;
            if (bit_total == 0 && have_full) begin
               full_byte.last_byte = 1'b1;
            end
            if (have_full) begin
               expected_bytes.push_back(full_byte);
            end
            if (bit_total != 0) begin
               flush_byte.packed_byte = 8'(window << (8 - bit_total));
               flush_byte.last_byte = 1'b1;
               expected_bytes.push_back(flush_byte);
            end
            pending_bits = 8'd0;
            pending_count = 3'd0;
         end else begin
            if (have_full) begin
               expected_bytes.push_back(full_byte);
            end
            pending_bits = window[7:0];
            pending_count = 3'(bit_total);
         end
         pixels_noted++;
      endfunction

      // Compare one delivered byte with the oldest prediction.
      function void check_response(input logic [7:0] packed_byte, input logic last_byte);
         pqbp_pkg::rsp_entry_type want;

         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            if (mismatches < 10) begin
               $display("tb: unexpected byte %02h last %0b", packed_byte, last_byte);
            end
            mismatches++;
         end else begin
            want = expected_bytes.pop_front();
            if (packed_byte !== want.packed_byte || last_byte !== want.last_byte) begin
               if (mismatches < 10) begin
                  $display("tb: byte mismatch: expected %02h last %0b, got %02h last %0b",
                           want.packed_byte, want.last_byte, packed_byte, last_byte);
               end
               mismatches++;
            end
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_pixel;
   logic       req_end_of_image;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_packed_byte;
   logic       rsp_last_byte;
   logic       csr_write_enable;
   logic [2:0] csr_write_data;

   packer_scoreboard stream_board = new();
   bit               sender_steady;
   logic [7:0]       widths_seen;

   pixel_quantize_bit_packer_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .req_end_of_image (req_end_of_image),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_packed_byte  (rsp_packed_byte),
      .rsp_last_byte    (rsp_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
   end
   always #(HalfPeriod) clock = ~clock;

   // Offer one pixel, possibly after some idle cycles, and hold it until accepted.
   // Entered and left at a falling edge. Ready only changes at a rising edge, so the
   // value read at the falling edge is the one the next rising edge sees.
   task automatic send_pixel(input logic [7:0] pixel, input logic end_of_image);
      bit accepted;

      while (!sender_steady && $urandom_range(0, 99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pixel;
      req_end_of_image <= end_of_image;
      do begin
         accepted = (req_ready === 1'b1);
         @(posedge clock);
         if (!accepted) begin
            @(negedge clock);
         end
      end while (!accepted);
      stream_board.note_request(pixel, end_of_image);
      @(negedge clock);
   endtask

   // Wait until every predicted byte has arrived and the core has settled.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (stream_board.outstanding() != 0) begin
         @(negedge clock);
      end
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Change the code width while the core is quiet; pending bits stay in place.
   task automatic write_width(input logic [2:0] width);
      wait_quiet();
      csr_write_enable <= 1'b1;
      csr_write_data <= width;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      stream_board.set_width(width);
      widths_seen[width] = 1'b1;
   endtask

   // Receiver: random back-pressure, one long hold-off and one stretch with none.
   initial begin
      int unsigned hold_left;
      bit          hold_done;
      bit          steady;
      bit          ready_now;
      bit          take;
      logic [7:0]  seen_byte;
      logic        seen_last;

      hold_left = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         if (!hold_done && stream_board.bytes_checked >= 250) begin
            hold_done = 1'b1;
            hold_left = HoldOffCycles;
         end
         steady = stream_board.bytes_checked >= 500 && stream_board.bytes_checked < 800;
         if (hold_left != 0) begin
            hold_left--;
            ready_now = 1'b0;
         end else begin
            ready_now = steady || ($urandom_range(0, 99) >= IdlePercent);
         end
         rsp_ready <= ready_now;
         // The response side only changes at a rising edge, so these are the edge's values.
         take = ready_now && (rsp_valid === 1'b1);
         seen_byte = rsp_packed_byte;
         seen_last = rsp_last_byte;
         @(posedge clock);
         if (take) begin
            stream_board.check_response(seen_byte, seen_last);
         end
         @(negedge clock);
      end
   end

   // Watchdog for a hung or starved run.
   initial begin
      #(TimeoutCycles * 2 * HalfPeriod);
      $display("tb: failure");
      $finish;
   end

   // Reset, directed requests, then random images over changing code widths.
   initial begin
      int unsigned sent;
      int unsigned phase_left;
      int unsigned image_left;
      int unsigned phase_index;
      logic [2:0]  width;
      logic [7:0]  pixel;
      logic [2:0]  width_plan[8];

      width_plan = '{3'd1, 3'd7, 3'd0, 3'd4, 3'd2, 3'd7, 3'd5, 3'd1};
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel = 8'd0;
      req_end_of_image = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 3'd0;
      sender_steady = 1'b0;
      widths_seen = 8'd0;
      widths_seen[pqbp_pkg::WidthReset] = 1'b1;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset width: extremes, an image ending exactly on a byte, a lone flush.
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hA5, 1'b0);
      send_pixel(8'h5A, 1'b1);
      send_pixel(8'h80, 1'b1);
      // Widest code: a pixel that completes a byte and also flushes.
      write_width(3'd7);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h01, 1'b0);
      send_pixel(8'hFE, 1'b1);
      write_width(3'd1);
      send_pixel(8'h80, 1'b0);
      send_pixel(8'h7F, 1'b0);
      send_pixel(8'hFF, 1'b1);
      // Zero width: pixels add nothing, and an empty end of image yields no byte.
      write_width(3'd0);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h12, 1'b1);
      // Width change in the middle of an image keeps the pending bits.
      write_width(3'd3);
      send_pixel(8'hE0, 1'b0);
      write_width(3'd0);
      send_pixel(8'h55, 1'b1);
      write_width(3'd5);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hAB, 1'b1);
      write_width(3'd6);
      send_pixel(8'hC3, 1'b0);
      send_pixel(8'h3C, 1'b1);
      write_width(3'd2);
      send_pixel(8'h40, 1'b1);

      // Random images; phases switch width, often while an image is open.
      sent = 0;
      image_left = 0;
      phase_index = 0;
      while (sent < RandomPixels) begin
         width = (phase_index < 8) ? width_plan[phase_index] : 3'($urandom_range(0, 7));
         phase_index++;
         write_width(width);
         phase_left = (width == 3'd0) ? $urandom_range(10, 40) : $urandom_range(60, 200);
         while (phase_left != 0 && sent < RandomPixels) begin
            if (image_left == 0) begin
               image_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 48);
            end
            case ($urandom_range(0, 9))
               0: pixel = 8'h00;
               1: pixel = 8'hFF;
               default: pixel = 8'($urandom_range(0, 255));
            endcase
            sender_steady = sent >= 500 && sent < 800;
            send_pixel(pixel, image_left == 1);
            image_left--;
            phase_left--;
            sent++;
         end
      end

      wait_quiet();
      repeat (DrainCycles) @(negedge clock);
      $display("tb: %0d pixels in %0d images, %0d bytes checked, width mask %08b",
               stream_board.pixels_noted, stream_board.images_ended,
               stream_board.bytes_checked, widths_seen);
      $display("tb: %0d mismatches", stream_board.mismatches);
      if (stream_board.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
